>>> design/dnkg_pkg.sv
// Shared constants, control struct and register update functions of the dual NFSR generator.
package dnkg_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int LONG_W        = 90;
    localparam int SHORT_W       = 31;
    localparam int KEY_LO_W      = 64;
    localparam int KEY_HI_W      = 56;
    localparam int IV_W          = 64;
    localparam int CNT_W         = 7;
    localparam int MIX_STEPS     = 128;
    localparam int DIFF_STEPS    = 128;

    // input kinds
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_GEN  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_GEN       = 2'd0;
    localparam logic [1:0] STATUS_NO_INIT   = 2'd1;
    localparam logic [1:0] STATUS_INIT_DONE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_IV       = 2'd2;

    // per-cycle command to the shift register pair
    typedef struct packed {
        logic load;
        logic step;
        logic mix;
        logic key_add;
    } t_nfsr_ctl;

    // output bit of the current state
    function automatic logic out_bit(input logic [LONG_W-1:0] b, input logic [SHORT_W-1:0] s);
        logic l, q, t, tt;
        l  = b[7] ^ b[11] ^ b[30] ^ b[40] ^ b[45] ^ b[54] ^ b[71];
        q  = (b[4] & b[21]) ^ (b[9] & b[52]) ^ (b[18] & b[37]) ^ (b[44] & b[76]);
        t  = b[5] ^ (b[8] & b[82]) ^ (b[34] & b[67] & b[73])
           ^ (b[2] & b[28] & b[41] & b[65])
           ^ (b[13] & b[29] & b[50] & b[64] & b[75])
           ^ (b[6] & b[14] & b[26] & b[32] & b[47] & b[61])
           ^ (b[1] & b[19] & b[27] & b[43] & b[57] & b[66] & b[78]);
        tt = s[23] ^ (s[3] & s[16]) ^ (s[9] & s[13] & b[48])
           ^ (s[1] & s[24] & b[38] & b[63]);
        return l ^ q ^ t ^ tt;
    endfunction

    // feedback of the long register
    function automatic logic long_fb(input logic [LONG_W-1:0] b, input logic [SHORT_W-1:0] s);
        return s[0] ^ b[0] ^ b[24] ^ b[49] ^ b[79] ^ b[84]
             ^ (b[3] & b[59]) ^ (b[10] & b[12]) ^ (b[15] & b[16])
             ^ (b[25] & b[53]) ^ (b[35] & b[42]) ^ (b[55] & b[58])
             ^ (b[60] & b[74]) ^ (b[20] & b[22] & b[23])
             ^ (b[62] & b[68] & b[72]) ^ (b[77] & b[80] & b[81] & b[83]);
    endfunction

    // feedback of the short register
    function automatic logic short_fb(input logic [SHORT_W-1:0] s);
        return s[0] ^ s[2] ^ s[5] ^ s[6] ^ s[15] ^ s[17] ^ s[18] ^ s[20] ^ s[25]
             ^ (s[8] & s[18]) ^ (s[8] & s[20]) ^ (s[12] & s[21]) ^ (s[14] & s[19])
             ^ (s[17] & s[21]) ^ (s[20] & s[22]) ^ (s[4] & s[12] & s[22])
             ^ (s[4] & s[19] & s[22]) ^ (s[7] & s[20] & s[21])
             ^ (s[8] & s[18] & s[22]) ^ (s[8] & s[20] & s[22])
             ^ (s[12] & s[19] & s[22]) ^ (s[20] & s[21] & s[22])
             ^ (s[4] & s[7] & s[12] & s[21]) ^ (s[4] & s[7] & s[19] & s[21])
             ^ (s[4] & s[12] & s[21] & s[22]) ^ (s[4] & s[19] & s[21] & s[22])
             ^ (s[7] & s[8] & s[18] & s[21]) ^ (s[7] & s[8] & s[20] & s[21])
             ^ (s[7] & s[12] & s[19] & s[21]) ^ (s[8] & s[18] & s[21] & s[22])
             ^ (s[8] & s[20] & s[21] & s[22]) ^ (s[12] & s[19] & s[21] & s[22]);
    endfunction

endpackage

>>> design/dual_nfsr_keystream_generator_core.sv
// Initialize: load at the accepting edge, 128 mixing steps, a key addition, 128 diffusion steps;
// the result then passes from S_DONE into the output register once that is free.
// Generate: WORD_BITS shifts into the word register (bits past i_bit_count are zero),
// then via S_DONE to the output register; a generate before initialize goes to S_DONE.
// One word is worked on at a time; the next is taken while a result waits at the output.
// Reset (synchronous, active low) clears key, IV, shift registers and the initialized flag.
module dual_nfsr_keystream_generator_core #(
    parameter int WORD_BITS = dnkg_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [dnkg_pkg::KEY_LO_W-1:0] i_cfg_data,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [6:0]                    i_bit_count,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [WORD_BITS-1:0]          o_keystream_word,
    output logic [1:0]                    o_status
);
    import dnkg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MIX    = 3'd1;
    localparam logic [2:0] S_KEYADD = 3'd2;
    localparam logic [2:0] S_DIFF   = 3'd3;
    localparam logic [2:0] S_GEN    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [CNT_W-1:0] WB_CNT   = CNT_W'(WORD_BITS);
    localparam logic [CNT_W-1:0] GEN_LAST = CNT_W'(WORD_BITS - 1);
    localparam logic [CNT_W-1:0] MIX_LAST = CNT_W'(MIX_STEPS - 1);
    localparam logic [CNT_W-1:0] DIF_LAST = CNT_W'(DIFF_STEPS - 1);

    logic [KEY_LO_W-1:0]  r_key_low;
    logic [KEY_HI_W-1:0]  r_key_high;
    logic [IV_W-1:0]      r_iv;
    logic [2:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_cnt,   n_cnt;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [WORD_BITS-1:0] r_word,  n_word;
    logic [1:0]           r_status, n_status;
    logic                 r_init,  n_init;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_word;
    logic [1:0]           r_out_status;
    logic                 accept;
    logic                 gen_live;
    logic                 ks_bit;
    logic                 out_free;
    t_nfsr_ctl            ctl;

    assign o_in_ready       = (r_state == S_IDLE);
    assign accept           = i_in_valid & o_in_ready;
    assign out_free         = !r_out_valid || i_out_ready;
    assign gen_live         = (r_cnt < r_count);
    assign o_out_valid      = r_out_valid;
    assign o_keystream_word = r_out_word;
    assign o_status         = r_out_status;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv       <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data[KEY_HI_W-1:0];
                CFG_IV:       r_iv       <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // commands to the shift register pair
    always_comb begin
        ctl.load    = accept && (i_kind == KIND_INIT);
        ctl.mix     = (r_state == S_MIX);
        ctl.key_add = (r_state == S_KEYADD);
        ctl.step    = (r_state == S_MIX) || (r_state == S_DIFF)
                   || ((r_state == S_GEN) && gen_live);
    end

    dnkg_nfsr u_nfsr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_iv       (r_iv),
        .o_out_bit  (ks_bit)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_count  = r_count;
        n_word   = r_word;
        n_status = r_status;
        n_init   = r_init;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt  = '0;
                    n_word = '0;
                    if (i_kind == KIND_INIT) begin
                        n_status = STATUS_INIT_DONE;
                        n_state  = S_MIX;
                    end else if (!r_init) begin
                        n_status = STATUS_NO_INIT;
                        n_state  = S_DONE;
                    end else begin
                        n_status = STATUS_GEN;
                        n_count  = (i_bit_count > WB_CNT) ? WB_CNT : i_bit_count;
                        n_state  = S_GEN;
                    end
                end
            end
            S_MIX: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MIX_LAST) begin
                    n_cnt   = '0;
                    n_state = S_KEYADD;
                end
            end
            S_KEYADD: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIF_LAST) begin
                    n_init  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_GEN: begin
                // shift in at the top; after WORD_BITS shifts the first bit sits in bit 0
                n_word = (r_word >> 1)
                       | (WORD_BITS'(ks_bit & gen_live) << (WORD_BITS - 1));
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == GEN_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_init  <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_word   <= n_word;
        r_status <= n_status;
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_word   <= r_word;
            r_out_status <= r_status;
        end
    end

endmodule

>>> design/dnkg_nfsr.sv
// 90-bit and 31-bit NFSR pair: load, key addition, one step a cycle on i_ctl.step.
module dnkg_nfsr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dnkg_pkg::t_nfsr_ctl           i_ctl,
    input  logic [dnkg_pkg::KEY_LO_W-1:0] i_key_low,
    input  logic [dnkg_pkg::KEY_HI_W-1:0] i_key_high,
    input  logic [dnkg_pkg::IV_W-1:0]     i_iv,
    output logic                          o_out_bit
);
    import dnkg_pkg::*;

    logic [LONG_W-1:0]  r_long,  n_long;
    logic [SHORT_W-1:0] r_short, n_short;
    logic [SHORT_W-2:0] key_short;
    logic               extra;
    logic               fb_l, fb_s;

    assign key_short = i_key_high[KEY_HI_W-1:LONG_W-KEY_LO_W];
    assign o_out_bit = out_bit(r_long, r_short);

    // feed the output bit back during mixing
    assign extra = i_ctl.mix & o_out_bit;
    assign fb_l  = long_fb(r_long, r_short) ^ extra;
    assign fb_s  = short_fb(r_short) ^ extra;

    // next state
    always_comb begin
        n_long  = r_long;
        n_short = r_short;
        if (i_ctl.load) begin
            n_long  = {i_key_high[LONG_W-KEY_LO_W-1:0], i_key_low ^ i_iv};
            n_short = {1'b1, ~key_short[SHORT_W-2], key_short[SHORT_W-3:0]};
        end else if (i_ctl.key_add) begin
            n_long  = r_long ^ {i_key_high[LONG_W-KEY_LO_W-1:0], i_key_low};
            n_short = (r_short ^ {1'b0, key_short}) | {1'b1, {(SHORT_W-1){1'b0}}};
        end else if (i_ctl.step) begin
            n_long  = {fb_l, r_long[LONG_W-1:1]};
            n_short = {fb_s, r_short[SHORT_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long  <= '0;
            r_short <= '0;
        end else begin
            r_long  <= n_long;
            r_short <= n_short;
        end
    end

endmodule
